// ----- sv/i2cmbe_pkg.sv -----
// Package for the I2C master bit engine: sequencer steps, request codes, config register indexes, reset constants.
package i2cmbe_pkg;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'd0,
        ST_S_SCL0  = 5'd1,
        ST_S_SDA1  = 5'd2,
        ST_S_SCL1  = 5'd3,
        ST_S_DLY   = 5'd4,
        ST_S_SDA0  = 5'd5,
        ST_S_END   = 5'd6,
        ST_P_SCL0  = 5'd7,
        ST_P_SDA0  = 5'd8,
        ST_P_SCL1  = 5'd9,
        ST_P_DLY   = 5'd10,
        ST_P_END   = 5'd11,
        ST_A_SCL0  = 5'd12,
        ST_A_SDA   = 5'd13,
        ST_A_DLY1  = 5'd14,
        ST_A_SCL1  = 5'd15,
        ST_A_DLY2  = 5'd16,
        ST_A_END   = 5'd17,
        ST_W_SCL0  = 5'd18,
        ST_W_SCL1  = 5'd19,
        ST_W_DLY   = 5'd20,
        ST_W_POLL  = 5'd21,
        ST_W_END   = 5'd22,
        ST_B_SCL0  = 5'd23,
        ST_B_SDA   = 5'd24,
        ST_B_SCL1  = 5'd25,
        ST_B_DLY1  = 5'd26,
        ST_B_SCL0B = 5'd27,
        ST_B_DLY2  = 5'd28
    } t_step;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_START  = 3'd1,
        REQ_STOP   = 3'd2,
        REQ_WRITE  = 3'd3,
        REQ_WAIT   = 3'd4,
        REQ_READ   = 3'd5,
        REQ_ACKBIT = 3'd6,
        REQ_NOP    = 3'd7
    } t_req;

    // config register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd2;
    localparam logic [7:0] POLL_LIMIT_RST  = 8'd50;
    localparam logic [2:0] LAST_BIT        = 3'd7;

endpackage

// ----- sv/i2c_master_bit_engine.sv -----
// I2C master bit engine: tick-driven open-drain SCL/SDA sequencer with output register.
// Its result is in the output register in the cycle after an item is accepted.
// Throughput: one item per cycle while results are taken; the pin sequencer advances one step per accepted
// item, and the output register takes a new item when empty or as its result is taken (ready = !full | taken).
// Reset (synchronous, active low): sequencer idle, SCL and SDA released, all counters zero,
// half period 2 ticks, ack poll limit 50, output register empty.
module i2c_master_bit_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // wr_data[7:0], ack_after_read[8], sda_in[9], zero[15:10]
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // result item stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // scl[0], sda_release[1], busy_res[2], rx_data[10:3],
                                     // done_res[11], ack_seen[12], timed_out[13],
                                     // rejected[14], zero[15]
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    // config registers
    logic [7:0] r_half_period;
    logic [7:0] r_poll_limit;

    // sequencer state
    i2cmbe_pkg::t_step r_step, n_step;
    logic [2:0] r_active, n_active;
    logic [2:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_delay, n_delay;
    logic [7:0] r_poll, n_poll;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_data;

    // unpacked input fields
    i2cmbe_pkg::t_req w_req;
    logic [7:0] w_wr_data;
    logic       w_ack_in;
    logic       w_sda_in;
    logic       w_is_cmd;
    logic       w_fire;
    logic       w_start;
    logic       w_run;

    // effective state: a command taken while idle runs its first step on the same item
    i2cmbe_pkg::t_step e_step;
    logic [2:0] e_active;
    logic [2:0] e_bit_idx;
    logic [7:0] e_shift;
    logic [7:0] e_delay;
    logic [7:0] e_poll;
    logic       e_ack_choice;

    logic [7:0] w_hp;
    logic [7:0] w_delay_inc;
    logic       w_delay_hit;
    logic       w_is_read;

    // result flags of this item
    logic       f_done;
    logic       f_ack;
    logic       f_tmo;
    logic [7:0] f_rx;
    logic       w_rej;

    assign w_req     = i2cmbe_pkg::t_req'(i_s_tuser);
    assign w_wr_data = i_s_tdata[7:0];
    assign w_ack_in  = i_s_tdata[8];
    assign w_sda_in  = i_s_tdata[9];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_fire     = i_s_tvalid && o_s_tready;
    assign w_is_cmd   = (w_req != i2cmbe_pkg::REQ_TICK) && (w_req != i2cmbe_pkg::REQ_NOP);
    assign w_start    = (r_step == i2cmbe_pkg::ST_IDLE) && w_is_cmd;
    assign w_run      = (r_step != i2cmbe_pkg::ST_IDLE) || w_is_cmd;
    assign w_rej      = (r_step != i2cmbe_pkg::ST_IDLE) && w_is_cmd;

    // latch a new command: clear counters and pick the entry step
    always_comb begin
        e_step       = r_step;
        e_active     = r_active;
        e_bit_idx    = r_bit_idx;
        e_shift      = r_shift;
        e_delay      = r_delay;
        e_poll       = r_poll;
        e_ack_choice = r_ack_choice;
        if (w_start) begin
            e_active     = w_req;
            e_bit_idx    = '0;
            e_shift      = '0;
            e_delay      = '0;
            e_poll       = '0;
            e_ack_choice = w_ack_in;
            unique case (w_req)
                i2cmbe_pkg::REQ_START: e_step = i2cmbe_pkg::ST_S_SCL0;
                i2cmbe_pkg::REQ_STOP:  e_step = i2cmbe_pkg::ST_P_SCL0;
                i2cmbe_pkg::REQ_WRITE: begin
                    e_shift = w_wr_data;
                    e_step  = i2cmbe_pkg::ST_B_SCL0;
                end
                i2cmbe_pkg::REQ_WAIT:  e_step = i2cmbe_pkg::ST_W_SCL0;
                i2cmbe_pkg::REQ_READ:  e_step = i2cmbe_pkg::ST_B_SCL0;
                default:               e_step = i2cmbe_pkg::ST_A_SCL0;
            endcase
        end
    end

    // a zero half period still takes one tick
    assign w_hp        = (r_half_period == '0) ? 8'd1 : r_half_period;
    assign w_delay_inc = e_delay + 8'd1;
    assign w_delay_hit = (w_delay_inc >= w_hp);
    assign w_is_read   = (e_active == i2cmbe_pkg::REQ_READ);

    // next step
    always_comb begin
        n_step = r_step;
        if (w_run) begin
            unique case (e_step)
                i2cmbe_pkg::ST_S_SCL0:  n_step = i2cmbe_pkg::ST_S_SDA1;
                i2cmbe_pkg::ST_S_SDA1:  n_step = i2cmbe_pkg::ST_S_SCL1;
                i2cmbe_pkg::ST_S_SCL1:  n_step = i2cmbe_pkg::ST_S_DLY;
                i2cmbe_pkg::ST_S_DLY:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_S_SDA0 : i2cmbe_pkg::ST_S_DLY;
                i2cmbe_pkg::ST_S_SDA0:  n_step = i2cmbe_pkg::ST_S_END;
                i2cmbe_pkg::ST_S_END:   n_step = i2cmbe_pkg::ST_IDLE;
                i2cmbe_pkg::ST_P_SCL0:  n_step = i2cmbe_pkg::ST_P_SDA0;
                i2cmbe_pkg::ST_P_SDA0:  n_step = i2cmbe_pkg::ST_P_SCL1;
                i2cmbe_pkg::ST_P_SCL1:  n_step = i2cmbe_pkg::ST_P_DLY;
                i2cmbe_pkg::ST_P_DLY:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_P_END : i2cmbe_pkg::ST_P_DLY;
                i2cmbe_pkg::ST_P_END:   n_step = i2cmbe_pkg::ST_IDLE;
                i2cmbe_pkg::ST_A_SCL0:  n_step = i2cmbe_pkg::ST_A_SDA;
                i2cmbe_pkg::ST_A_SDA:
                    n_step = e_ack_choice ? i2cmbe_pkg::ST_A_DLY1 : i2cmbe_pkg::ST_A_SCL1;
                i2cmbe_pkg::ST_A_DLY1:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_A_SCL1 : i2cmbe_pkg::ST_A_DLY1;
                i2cmbe_pkg::ST_A_SCL1:  n_step = i2cmbe_pkg::ST_A_DLY2;
                i2cmbe_pkg::ST_A_DLY2:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_A_END : i2cmbe_pkg::ST_A_DLY2;
                i2cmbe_pkg::ST_A_END:   n_step = i2cmbe_pkg::ST_IDLE;
                i2cmbe_pkg::ST_W_SCL0:  n_step = i2cmbe_pkg::ST_W_SCL1;
                i2cmbe_pkg::ST_W_SCL1:  n_step = i2cmbe_pkg::ST_W_DLY;
                i2cmbe_pkg::ST_W_DLY:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_W_POLL : i2cmbe_pkg::ST_W_DLY;
                i2cmbe_pkg::ST_W_POLL: begin
                    if (!w_sda_in)
                        n_step = i2cmbe_pkg::ST_W_END;
                    else if (e_poll >= r_poll_limit)
                        n_step = i2cmbe_pkg::ST_P_SCL0;   // give up: send a stop
                    else
                        n_step = i2cmbe_pkg::ST_W_POLL;
                end
                i2cmbe_pkg::ST_W_END:   n_step = i2cmbe_pkg::ST_IDLE;
                i2cmbe_pkg::ST_B_SCL0:
                    n_step = w_is_read ? i2cmbe_pkg::ST_B_SCL1 : i2cmbe_pkg::ST_B_SDA;
                i2cmbe_pkg::ST_B_SDA:   n_step = i2cmbe_pkg::ST_B_SCL1;
                i2cmbe_pkg::ST_B_SCL1:  n_step = i2cmbe_pkg::ST_B_DLY1;
                i2cmbe_pkg::ST_B_DLY1:
                    n_step = w_delay_hit ? i2cmbe_pkg::ST_B_SCL0B : i2cmbe_pkg::ST_B_DLY1;
                i2cmbe_pkg::ST_B_SCL0B: n_step = i2cmbe_pkg::ST_B_DLY2;
                i2cmbe_pkg::ST_B_DLY2: begin
                    if (!w_delay_hit)
                        n_step = i2cmbe_pkg::ST_B_DLY2;
                    else if (e_bit_idx != i2cmbe_pkg::LAST_BIT)
                        n_step = w_is_read ? i2cmbe_pkg::ST_B_SCL1 : i2cmbe_pkg::ST_B_SDA;
                    else
                        n_step = w_is_read ? i2cmbe_pkg::ST_A_SCL0 : i2cmbe_pkg::ST_IDLE;
                end
                default:                n_step = i2cmbe_pkg::ST_IDLE;
            endcase
        end
    end

    // pin levels, counters and result flags
    always_comb begin
        n_active     = e_active;
        n_bit_idx    = e_bit_idx;
        n_shift      = e_shift;
        n_delay      = e_delay;
        n_poll       = e_poll;
        n_ack_choice = e_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        f_done       = 1'b0;
        f_ack        = 1'b0;
        f_tmo        = 1'b0;
        f_rx         = '0;
        if (w_run) begin
            unique case (e_step)
                i2cmbe_pkg::ST_S_SCL0, i2cmbe_pkg::ST_P_SCL0, i2cmbe_pkg::ST_A_SCL0:
                    n_scl = 1'b0;
                i2cmbe_pkg::ST_S_SDA1:  n_sda = 1'b1;
                i2cmbe_pkg::ST_S_SCL1, i2cmbe_pkg::ST_P_SCL1, i2cmbe_pkg::ST_A_SCL1,
                i2cmbe_pkg::ST_W_SCL1, i2cmbe_pkg::ST_B_SCL1:
                    n_scl = 1'b1;
                i2cmbe_pkg::ST_S_DLY, i2cmbe_pkg::ST_P_DLY, i2cmbe_pkg::ST_A_DLY1,
                i2cmbe_pkg::ST_A_DLY2, i2cmbe_pkg::ST_W_DLY, i2cmbe_pkg::ST_B_DLY1:
                    n_delay = w_delay_hit ? 8'd0 : w_delay_inc;
                i2cmbe_pkg::ST_S_SDA0, i2cmbe_pkg::ST_P_SDA0:
                    n_sda = 1'b0;
                i2cmbe_pkg::ST_S_END: begin
                    n_scl  = 1'b0;
                    f_done = 1'b1;
                end
                i2cmbe_pkg::ST_P_END: begin
                    n_sda  = 1'b1;
                    f_done = 1'b1;
                    f_tmo  = (e_active == i2cmbe_pkg::REQ_WAIT);
                end
                i2cmbe_pkg::ST_A_SDA:   n_sda = !e_ack_choice;
                i2cmbe_pkg::ST_A_END: begin
                    n_scl  = 1'b0;
                    f_done = 1'b1;
                    f_rx   = w_is_read ? e_shift : 8'd0;
                end
                i2cmbe_pkg::ST_W_SCL0: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                i2cmbe_pkg::ST_W_POLL: begin
                    if (w_sda_in && (e_poll < r_poll_limit))
                        n_poll = e_poll + 8'd1;
                end
                i2cmbe_pkg::ST_W_END: begin
                    n_scl  = 1'b0;
                    f_done = 1'b1;
                    f_ack  = 1'b1;
                end
                i2cmbe_pkg::ST_B_SCL0: begin
                    n_scl = 1'b0;
                    if (w_is_read)
                        n_sda = 1'b1;
                end
                i2cmbe_pkg::ST_B_SDA: begin
                    n_sda   = e_shift[7];
                    n_shift = {e_shift[6:0], 1'b0};
                end
                i2cmbe_pkg::ST_B_SCL0B: begin
                    n_scl = 1'b0;
                    if (w_is_read)
                        n_shift = {e_shift[6:0], w_sda_in};
                end
                i2cmbe_pkg::ST_B_DLY2: begin
                    n_delay = w_delay_hit ? 8'd0 : w_delay_inc;
                    if (w_delay_hit) begin
                        if (e_bit_idx != i2cmbe_pkg::LAST_BIT)
                            n_bit_idx = e_bit_idx + 3'd1;
                        else if (!w_is_read)
                            f_done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cmbe_pkg::HALF_PERIOD_RST;
            r_poll_limit  <= i2cmbe_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                i2cmbe_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_wdata;
                i2cmbe_pkg::CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= i2cmbe_pkg::ST_IDLE;
            r_active     <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else if (w_fire) begin
            r_step       <= n_step;
            r_active     <= n_active;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    // output register: valid is control, payload loads on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_fire)
            r_out_valid <= 1'b1;
        else if (i_m_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire)
            r_out_data <= {1'b0, w_rej, f_tmo, f_ack, f_done, f_rx,
                           (n_step != i2cmbe_pkg::ST_IDLE), n_sda, n_scl};
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // a finished command never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[11]) |-> !o_m_tdata[2])
        else $error("done result still reports busy");

    // timeout ends the command as a NACK
    a_tmo_is_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[13]) |-> (o_m_tdata[11] && !o_m_tdata[12]))
        else $error("timeout without done or with ack");

    // an item taken while idle is never rejected
    a_idle_no_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_step == i2cmbe_pkg::ST_IDLE)) |=> !r_out_data[14])
        else $error("item rejected while idle");

    // delay counter is clear whenever the sequencer is idle
    a_idle_delay_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == i2cmbe_pkg::ST_IDLE) |-> (r_delay == 8'd0))
        else $error("delay count left over after command");

endmodule
